// File: src/mst_pkg.sv
// shared types and constants for the missing sequence tracker
// item and result payload structs, kind codes, field widths
// no dependencies
package mst_pkg;

    localparam int ENTRIES_DEFAULT = 4096;

    localparam int KIND_W  = 2;
    localparam int SEQ_W   = 16;
    localparam int LAST_W  = 12;
    localparam int COUNT_W = 13;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 2;

    // bitmap memory word and the split of a sequence into word and bit
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int WIDX_W  = SEQ_W - BIT_W;
    localparam int SWORD_W = LAST_W - BIT_W;

    localparam logic [KIND_W-1:0] KIND_ARRIVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LAST_SEQ = 2'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_num;
    } item_t;

    typedef struct packed {
        logic               new_packet;
        logic               missing_found;
        logic [LAST_W-1:0]  missing_seq;
        logic               all_received;
        logic [COUNT_W-1:0] arrived_count;
    } result_t;

endpackage

// File: src/missing_sequence_tracker.sv
// missing sequence tracker for a selective-repeat receiver
// bitmap in a 32-bit wide synchronous memory, control fsm, apb register
// depends on mst_pkg

// The tracker keeps one received bit per sequence number 0..last_seq in a
// memory of 32-bit words (one read and one write port, read data registered)
// and handles one item at a time. An arrival reads the word holding its bit,
// then sets the bit and bumps the arrival count if the sequence is in range
// and new. A poll reads the words from the scan pointer onwards, one word per
// cycle, and stops at the first hole or at the word holding the last
// sequence. A clear item writes zero to every word, one word per cycle.
// After reset the same clearing sweep runs and item_ready stays low until it
// ends; apb writes are taken throughout. The result register lets the next
// item be accepted while a result still waits. last_seq is clamped to
// ENTRIES-1 and should only be written while the tracker is idle.
module missing_sequence_tracker
    import mst_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // items
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // results
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    localparam int WORDS = (ENTRIES + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [SEQ_W:0]  LIMIT     = (SEQ_W + 1)'(ENTRIES - 1);
    localparam logic [AW-1:0]   LAST_WORD = AW'(WORDS - 1);

    // one-hot control states
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,   // zeroing sweep over the bitmap
        S_IDLE  = 5'b00010,   // waiting for an item
        S_ARR   = 5'b00100,   // arrival word in hand, modify and write back
        S_SCAN  = 5'b01000,   // poll, one word checked per cycle
        S_DONE  = 5'b10000    // hand the result to the output register
    } state_t;

    state_t               state_reg, state_next;
    logic [LAST_W-1:0]    last_seq_reg, last_seq_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LAST_W-1:0]    scan_reg, scan_next;
    logic [AW-1:0]        clr_word_reg, clr_word_next;
    logic                 clr_item_reg, clr_item_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [SWORD_W-1:0]   chk_word_reg, chk_word_next;
    result_t              res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    // bitmap memory
    logic [WORD_W-1:0]    mem [WORDS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;

    logic [LAST_W-1:0]    eff_last;
    logic [COUNT_W-1:0]   total;
    logic                 accept;
    logic                 cfg_write;
    logic                 arr_hit;
    logic [WORD_W-1:0]    lo_mask;
    logic [WORD_W-1:0]    hi_mask;
    logic [WORD_W-1:0]    hole;
    logic [BIT_W-1:0]     hole_idx;
    logic [LAST_W-1:0]    miss;

    function automatic logic [AW-1:0] to_addr(input logic [WIDX_W-1:0] w);
        return w[AW-1:0];
    endfunction

    // last sequence limited to the bitmap size
    assign eff_last = ({{(SEQ_W + 1 - LAST_W){1'b0}}, last_seq_reg} > LIMIT)
                      ? LIMIT[LAST_W-1:0] : last_seq_reg;
    assign total    = {1'b0, eff_last} + COUNT_W'(1);

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_LAST_SEQ);
    assign prdata    = (paddr == ADDR_LAST_SEQ)
                       ? {{(DATA_W - LAST_W){1'b0}}, last_seq_reg} : '0;

    // arrival: in range and bit not yet set
    assign arr_hit = ({{(SEQ_W - LAST_W){1'b0}}, eff_last} >= seq_reg)
                     && !rd_data_reg[seq_reg[BIT_W-1:0]];

    // scan masks: skip bits before the pointer and after the last sequence
    assign lo_mask = (chk_word_reg == scan_reg[LAST_W-1:BIT_W])
                     ? ({WORD_W{1'b1}} << scan_reg[BIT_W-1:0]) : {WORD_W{1'b1}};
    assign hi_mask = (chk_word_reg == eff_last[LAST_W-1:BIT_W])
                     ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - eff_last[BIT_W-1:0]))
                     : {WORD_W{1'b1}};
    assign hole    = ~rd_data_reg & lo_mask & hi_mask;

    // lowest hole in the word
    always_comb
    begin
        hole_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (hole[b])
            begin
                hole_idx = BIT_W'(b);
            end
        end
    end

    assign miss = {chk_word_reg, hole_idx};

    always_comb
    begin
        state_next     = state_reg;
        last_seq_next  = cfg_write ? pwdata[LAST_W-1:0] : last_seq_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        clr_word_next  = clr_word_reg;
        clr_item_next  = clr_item_reg;
        seq_next       = seq_reg;
        chk_word_next  = chk_word_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_word_reg;
                if (clr_word_reg == LAST_WORD)
                begin
                    count_next             = '0;
                    scan_next              = '0;
                    res_next               = '0;
                    res_next.all_received  = (total == '0);
                    state_next             = clr_item_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_word_next = clr_word_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_next               = '0;
                    res_next.all_received  = (count_reg == total);
                    res_next.arrived_count = count_reg;
                    case (item.kind)
                        KIND_ARRIVE:
                        begin
                            seq_next   = item.seq_num;
                            rd_addr    = to_addr(item.seq_num[SEQ_W-1:BIT_W]);
                            state_next = S_ARR;
                        end
                        KIND_POLL:
                        begin
                            if (scan_reg > eff_last)
                            begin
                                // pointer beyond the last sequence finds nothing
                                scan_next  = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                chk_word_next = scan_reg[LAST_W-1:BIT_W];
                                rd_addr       = to_addr(WIDX_W'(scan_reg[LAST_W-1:BIT_W]));
                                state_next    = S_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            clr_word_next = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ARR:
            begin
                wr_en   = arr_hit;
                wr_addr = to_addr(seq_reg[SEQ_W-1:BIT_W]);
                wr_data = rd_data_reg | (WORD_W'(1) << seq_reg[BIT_W-1:0]);
                if (arr_hit)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                res_next.new_packet    = arr_hit;
                res_next.arrived_count = count_next;
                res_next.all_received  = (count_next == total);
                state_next             = S_DONE;
            end

            S_SCAN:
            begin
                if (|hole)
                begin
                    res_next.missing_found = 1'b1;
                    res_next.missing_seq   = miss;
                    scan_next  = (miss == eff_last) ? '0 : miss + LAST_W'(1);
                    state_next = S_DONE;
                end
                else if (chk_word_reg == eff_last[LAST_W-1:BIT_W])
                begin
                    scan_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    chk_word_next = chk_word_reg + SWORD_W'(1);
                    rd_addr       = to_addr(WIDX_W'(chk_word_next));
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            last_seq_reg  <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            clr_word_reg  <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_seq_reg  <= last_seq_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            clr_word_reg  <= clr_word_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        chk_word_reg <= chk_word_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // bitmap memory, read data registered, valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    // the clearing sweep ends after its last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && (clr_word_reg == LAST_WORD) |=> (state_reg != S_CLEAR))
        else $error("clearing sweep did not finish");

    // the scan never runs past the word holding the last sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (chk_word_reg <= eff_last[LAST_W-1:BIT_W]))
        else $error("scan beyond last word");

    // a new arrival adds exactly one to the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARR) && arr_hit |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("arrival count not incremented");

    // an accepted item leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item not processed");
`endif

endmodule
